// ----- rtl/ses_pkg.sv -----
// ----------------------------------------------------------------------------
// ses_pkg: shared types and constants of the strip energy sharing block
// Field widths, register codes and the divider request/response bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ses_pkg;

	localparam int POS_W    = 24;  // world coordinate width
	localparam int ENERGY_W = 24;  // energy width
	localparam int LOC_W    = 25;  // coordinate after offset removal
	localparam int STRIP_W  = 26;  // full precision strip number
	localparam int SW_W     = 16;  // strip width register
	localparam int NS_W     = 9;   // strip count register
	localparam int BASE_W   = 9;   // num_strips/2 + 1
	localparam int LEN_W    = 16;  // path length inside one strip
	localparam int TOT_W    = 26;  // total path length

	// shared divider sizing
	localparam int DIV_W     = 40;  // dividend / quotient width
	localparam int DSR_W     = 26;  // divisor / remainder width
	localparam int NARROW_W  = 25;  // dividend width of a strip number division
	localparam int DCNT_W    = 6;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register index codes (byte address / 4)
	localparam logic [1:0] REG_OFFSET  = 2'd0;
	localparam logic [1:0] REG_WIDTH   = 2'd1;
	localparam logic [1:0] REG_NSTRIPS = 2'd2;

	localparam logic [POS_W-1:0] OFFSET_RST  = 24'd0;
	localparam logic [SW_W-1:0]  WIDTH_RST   = 16'd256;
	localparam logic [NS_W-1:0]  NSTRIPS_RST = 9'd40;

	typedef struct packed {
		logic             start;
		logic             narrow;    // dividend is NARROW_W bits wide
		logic [DIV_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/strip_energy_sharing.sv -----
// ----------------------------------------------------------------------------
// strip_energy_sharing: energy sharing of one step over the strips of an axis
// Locates the entry and exit strips, then walks them and credits each strip
// with energy * path_in_strip / total_path on one shared iterative divider.
// ----------------------------------------------------------------------------
// Sequence: a step that stays in one strip shows its beat after two strip number
//   divisions (entry, then exit) plus the load, check and emit states.
// A crossing step adds, per strip walked, one energy division on the shared
//   divider, a multiply state and an output state.
// Throughput: one step at a time; the next step is taken once the last beat of
//   the current one sits in the output register. Zero energy steps are dropped.
// Reset: arst_n clears control state and loads the register defaults
//   (offset 0, strip width 256, 40 strips); no clearing pass is needed.
`default_nettype none

module strip_energy_sharing
	import ses_pkg::*;
#(
	parameter int MAX_SPAN = 64
) (
	input  wire                        clk,
	input  wire                        arst_n,
	// APB configuration port
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire        [ADDR_W-1:0]    paddr,
	input  wire        [DATA_W-1:0]    pwdata,
	output logic       [DATA_W-1:0]    prdata,
	output logic                       pready,
	// step input
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire signed [POS_W-1:0]     entry_pos,
	input  wire signed [POS_W-1:0]     exit_pos,
	input  wire        [ENERGY_W-1:0]  energy,
	// strip result output
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic signed [POS_W-1:0]    strip_index,
	output logic       [ENERGY_W-1:0]  strip_energy,
	output logic                       span_overflow,
	output logic                       last
);

	localparam int SPAN_W = (MAX_SPAN > 2) ? $clog2(MAX_SPAN) : 1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_LOAD  = 8'b00000010,
		ST_DIV_A = 8'b00000100,
		ST_DIV_B = 8'b00001000,
		ST_CHECK = 8'b00010000,
		ST_MUL   = 8'b00100000,
		ST_DIV_E = 8'b01000000,
		ST_EMIT  = 8'b10000000
	} state_t;

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [POS_W-1:0] offset_q;
	logic [SW_W-1:0]  width_q;
	logic [NS_W-1:0]  nstrips_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= OFFSET_RST;
			width_q   <= WIDTH_RST;
			nstrips_q <= NSTRIPS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_OFFSET:  offset_q  <= pwdata[POS_W-1:0];
				REG_WIDTH:   width_q   <= pwdata[SW_W-1:0];
				REG_NSTRIPS: nstrips_q <= pwdata[NS_W-1:0];
				default: ; // unmapped address: drop the write
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OFFSET:  prdata = {(DATA_W - POS_W)'(0), offset_q};
			REG_WIDTH:   prdata = {(DATA_W - SW_W)'(0), width_q};
			REG_NSTRIPS: prdata = {(DATA_W - NS_W)'(0), nstrips_q};
			default:     prdata = '0;
		endcase
	end

	// A zero strip width acts as one; the index base is num_strips/2 + 1.
	logic [SW_W-1:0]   w_eff;
	logic [BASE_W-1:0] base;

	assign w_eff = (width_q == '0) ? SW_W'(1) : width_q;
	assign base  = BASE_W'(nstrips_q[NS_W-1:1]) + 1'b1;

	// ------------------------------------------------------------------------
	// Step state
	// ------------------------------------------------------------------------
	state_t                     state_q;
	logic signed [LOC_W-1:0]    a_q;      // entry, local coordinate
	logic signed [LOC_W-1:0]    b_q;      // exit, local coordinate
	logic [ENERGY_W-1:0]        e_q;
	logic signed [STRIP_W-1:0]  sa_q;     // entry strip
	logic signed [STRIP_W-1:0]  sb_q;     // exit strip
	logic [SW_W-1:0]            rfa_q;    // floor remainder of entry
	logic [SW_W-1:0]            rfb_q;    // floor remainder of exit
	logic signed [STRIP_W-1:0]  s_q;      // strip being credited
	logic [SPAN_W-1:0]          cnt_q;    // strips left after this one
	logic                       first_q;
	logic                       dir_q;    // walking toward higher strips
	logic [TOT_W-1:0]           total_q;

	// pending beat
	logic signed [POS_W-1:0]    res_idx_q;
	logic [ENERGY_W-1:0]        res_en_q;
	logic                       res_ovf_q;
	logic                       res_last_q;

	// output register
	logic                       out_valid_q;
	logic signed [POS_W-1:0]    strip_index_q;
	logic [ENERGY_W-1:0]        strip_energy_q;
	logic                       span_overflow_q;
	logic                       last_q;

	logic     in_acc;
	logic     out_load;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign out_load = (state_q == ST_EMIT) & (~out_valid_q | out_ready);

	// Clamp a full precision strip number to the 24-bit index field.
	function automatic logic signed [POS_W-1:0] sat_idx(input logic signed [STRIP_W-1:0] v);
		logic signed [STRIP_W-1:0] hi;
		logic signed [STRIP_W-1:0] lo;
		hi = STRIP_W'((1 << (POS_W - 1)) - 1);
		lo = -STRIP_W'(1 << (POS_W - 1));
		if (v > hi)
			return {1'b0, {(POS_W - 1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(POS_W - 1){1'b0}}};
		else
			return v[POS_W-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// Strip number from a truncated magnitude division: turn it into a floor
	// quotient and a floor remainder for a negative coordinate.
	// ------------------------------------------------------------------------
	logic                      fl_neg;
	logic [STRIP_W-1:0]        fl_qx;
	logic                      rem_zero;
	logic signed [STRIP_W-1:0] fl_q;
	logic [SW_W-1:0]           fl_rf;
	logic signed [STRIP_W-1:0] fl_strip;

	assign fl_neg   = (state_q == ST_DIV_A) ? a_q[LOC_W-1] : b_q[LOC_W-1];
	assign fl_qx    = {1'b0, div_rsp.quotient[LOC_W-1:0]};
	assign rem_zero = (div_rsp.remainder[SW_W-1:0] == '0);
	assign fl_q     = fl_neg ? (~fl_qx + STRIP_W'(rem_zero)) : fl_qx;
	assign fl_rf    = (fl_neg && !rem_zero) ? (w_eff - div_rsp.remainder[SW_W-1:0])
	                                        : div_rsp.remainder[SW_W-1:0];
	assign fl_strip = fl_q + STRIP_W'(base);

	// magnitudes of the local coordinates
	logic [LOC_W-1:0] a_mag;
	logic [LOC_W-1:0] b_mag;

	assign a_mag = a_q[LOC_W-1] ? (-a_q) : a_q;
	assign b_mag = b_q[LOC_W-1] ? (-b_q) : b_q;

	// span and total path
	logic signed [STRIP_W:0] sdiff;
	logic [STRIP_W:0]        sdiff_mag;
	logic signed [TOT_W-1:0] tdiff;
	logic [TOT_W-1:0]        tdiff_mag;
	logic                    span_over;

	assign sdiff     = {sb_q[STRIP_W-1], sb_q} - {sa_q[STRIP_W-1], sa_q};
	assign sdiff_mag = sdiff[STRIP_W] ? (-sdiff) : sdiff;
	assign span_over = (sdiff_mag >= (STRIP_W + 1)'(MAX_SPAN));
	assign tdiff     = {b_q[LOC_W-1], b_q} - {a_q[LOC_W-1], a_q};
	assign tdiff_mag = tdiff[TOT_W-1] ? (-tdiff) : tdiff;

	// path inside the current strip: partial at either end, full in between
	logic [LEN_W-1:0]  len;
	logic [DIV_W-1:0]  prod;

	always_comb begin
		if (first_q)
			len = dir_q ? ((rfa_q == '0) ? '0 : (w_eff - rfa_q)) : rfa_q;
		else if (cnt_q == '0)
			len = dir_q ? rfb_q : ((rfb_q == '0) ? '0 : (w_eff - rfb_q));
		else
			len = w_eff;
	end

	assign prod = e_q * len;

	// energy share saturates to the field width
	logic [ENERGY_W-1:0] share;

	assign share = (div_rsp.quotient[DIV_W-1:ENERGY_W] != '0) ? '1
	                                                          : div_rsp.quotient[ENERGY_W-1:0];

	// ------------------------------------------------------------------------
	// Divider requests: strip number of entry, of exit, then one per strip
	// ------------------------------------------------------------------------
	always_comb begin
		div_req.start    = 1'b0;
		div_req.narrow   = 1'b1;
		div_req.dividend = {(DIV_W - LOC_W)'(0), a_mag};
		div_req.divisor  = {(DSR_W - SW_W)'(0), w_eff};
		unique case (state_q)
			ST_LOAD: begin
				div_req.start = 1'b1;
			end
			ST_DIV_A: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = {(DIV_W - LOC_W)'(0), b_mag};
			end
			ST_MUL: begin
				div_req.start    = 1'b1;
				div_req.narrow   = 1'b0;
				div_req.dividend = prod;
				div_req.divisor  = total_q;
			end
			default: ;
		endcase
	end

	ses_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// a zero energy step gives nothing: drop it here
					if (in_acc && energy != '0)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV_A;
				end
				ST_DIV_A: begin
					if (div_rsp.done)
						state_q <= ST_DIV_B;
				end
				ST_DIV_B: begin
					if (div_rsp.done)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (sa_q == sb_q || span_over)
						state_q <= ST_EMIT;
					else
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV_E;
				end
				ST_DIV_E: begin
					if (div_rsp.done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load)
						state_q <= res_last_q ? ST_IDLE : ST_MUL;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// step datapath, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q <= {entry_pos[POS_W-1], entry_pos} - {offset_q[POS_W-1], offset_q};
			b_q <= {exit_pos[POS_W-1], exit_pos} - {offset_q[POS_W-1], offset_q};
			e_q <= energy;
		end

		if (state_q == ST_DIV_A && div_rsp.done) begin
			sa_q  <= fl_strip;
			rfa_q <= fl_rf;
		end

		if (state_q == ST_DIV_B && div_rsp.done) begin
			sb_q  <= fl_strip;
			rfb_q <= fl_rf;
		end

		if (state_q == ST_CHECK) begin
			s_q        <= sa_q;
			first_q    <= 1'b1;
			dir_q      <= (sb_q > sa_q);
			cnt_q      <= sdiff_mag[SPAN_W-1:0];
			total_q    <= tdiff_mag;
			res_idx_q  <= sat_idx(sa_q);
			res_last_q <= 1'b1;
			// one strip takes it all; a too long walk gives one flagged beat
			res_en_q   <= (sa_q == sb_q) ? e_q : '0;
			res_ovf_q  <= (sa_q != sb_q);
		end

		if (state_q == ST_DIV_E && div_rsp.done) begin
			res_idx_q  <= sat_idx(s_q);
			res_en_q   <= share;
			res_ovf_q  <= 1'b0;
			res_last_q <= (cnt_q == '0);
		end

		// advance to the next strip once this beat is handed over
		if (out_load && !res_last_q) begin
			s_q     <= dir_q ? (s_q + 1'b1) : (s_q - 1'b1);
			cnt_q   <= cnt_q - 1'b1;
			first_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Output register: hold the beat until taken
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			strip_index_q   <= res_idx_q;
			strip_energy_q  <= res_en_q;
			span_overflow_q <= res_ovf_q;
			last_q          <= res_last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign strip_index   = strip_index_q;
	assign strip_energy  = strip_energy_q;
	assign span_overflow = span_overflow_q;
	assign last          = last_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_zero_energy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && energy == '0) |=> (state_q == ST_IDLE))
		else $error("zero energy step did not return to idle");

	a_div_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_A || state_q == ST_DIV_B || state_q == ST_DIV_E))
		else $error("divider finished outside a division state");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_valid_q && !out_ready) |=>
		(state_q == ST_EMIT && $stable(strip_index_q) && $stable(strip_energy_q)))
		else $error("pending beat overwrote a stalled output");

	a_last_at_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !res_ovf_q) |-> (res_last_q == (s_q == sb_q)))
		else $error("last flag does not match the exit strip");

	a_ovf_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && span_overflow_q) |-> (last_q && strip_energy_q == '0))
		else $error("overflow beat is not a lone empty beat");

endmodule

`default_nettype wire

// ----- rtl/ses_div.sv -----
// ----------------------------------------------------------------------------
// ses_div: shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses when the
// quotient and remainder are ready and they hold until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module ses_div
	import ses_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;

	logic [DSR_W:0] shifted;
	logic [DSR_W:0] trial;
	logic           q_bit;

	assign shifted = {rem_q, dvd_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dsr_q};
	assign q_bit   = ~trial[DSR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.narrow ? DCNT_W'(NARROW_W - 1) : DCNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// left-align a narrow dividend so its MSB enters first
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.narrow ? {req.dividend[NARROW_W-1:0], (DIV_W - NARROW_W)'(0)}
			                    : req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], q_bit};
			rem_q <= q_bit ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// ----- bench/strip_energy_sharing_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strip_energy_sharing_test: self-checking bench for strip energy sharing
// Feeds particle steps through a valid/ready driver, collects strip beats in
// a monitor and compares every beat with an in-bench prediction of the energy
// split, over several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------

module strip_energy_sharing_test;
	import ses_pkg::*;

	localparam int     HALF_PERIOD  = 5;
	localparam int     SPAN_LIMIT   = 64;
	localparam int     LONG_HOLD    = 3000;  // receiver hold-off, in cycles
	localparam int     DRAIN_CYCLES = 150;   // quiet time after the last beat
	// Worst case: 438 steps x 64 beats, each beat with its division and receiver stalls.
	localparam longint LIMIT_CYCLES = 64'd5000000;
	localparam longint POS_MAX      = 64'sd8388607;
	localparam longint POS_MIN      = -64'sd8388608;
	localparam longint ENERGY_MAX   = 64'sd16777215;

	typedef struct {
		logic signed [POS_W-1:0] entry_w;
		logic signed [POS_W-1:0] exit_w;
		logic [ENERGY_W-1:0]     amount;
	} step_t;

	typedef struct {
		logic signed [POS_W-1:0] index;
		logic [ENERGY_W-1:0]     share;
		logic                    ovf;
		logic                    fin;
	} strip_beat_t;

	// clock, reset and block inputs, all known from time zero
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic        [ADDR_W-1:0]   paddr     = '0;
	logic        [DATA_W-1:0]   pwdata    = '0;
	logic                       in_valid  = 1'b0;
	logic signed [POS_W-1:0]    entry_pos = '0;
	logic signed [POS_W-1:0]    exit_pos  = '0;
	logic        [ENERGY_W-1:0] energy    = '0;
	logic                       out_ready = 1'b0;

	wire         [DATA_W-1:0]   prdata;
	wire                        pready;
	wire                        in_ready;
	wire                        out_valid;
	wire  signed [POS_W-1:0]    strip_index;
	wire         [ENERGY_W-1:0] strip_energy;
	wire                        span_overflow;
	wire                        last;

	// bench copy of the registers, updated at the write edge
	logic signed [POS_W-1:0] cfg_offset  = OFFSET_RST;
	logic        [SW_W-1:0]  cfg_width   = WIDTH_RST;
	logic        [NS_W-1:0]  cfg_nstrips = NSTRIPS_RST;

	step_t       step_queue[$];      // steps waiting for the driver
	strip_beat_t pending_shares[$];  // predicted beats, oldest first

	bit     idle_on       = 1'b1;
	int     hold_requests = 0;
	int     holds_done    = 0;
	int     gap_left      = 0;
	int     stall_left    = 0;
	int     hold_left     = 0;
	int     mismatches    = 0;
	longint cycle_count   = 0;

	strip_energy_sharing #(
		.MAX_SPAN(SPAN_LIMIT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.entry_pos    (entry_pos),
		.exit_pos     (exit_pos),
		.energy       (energy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.strip_index  (strip_index),
		.strip_energy (strip_energy),
		.span_overflow(span_overflow),
		.last         (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Integer helpers: floor and ceil division (C division truncates,
	// and so does SystemVerilog, so correct the quotient by hand).
	// ------------------------------------------------------------------
	function automatic longint div_floor(longint num, longint den);
		longint q;
		q = num / den;
		if (num < 0 && (num % den) != 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint div_ceil(longint num, longint den);
		longint q;
		q = num / den;
		if (num > 0 && (num % den) != 0)
			q = q + 1;
		return q;
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
		if (v > POS_MAX)
			v = POS_MAX;
		if (v < POS_MIN)
			v = POS_MIN;
		return v[POS_W-1:0];
	endfunction

	// Saturate one strip share and queue it as an expected beat.
	task automatic push_share(longint strip, longint amt, logic ovf, logic fin);
		strip_beat_t bt;
		if (amt > ENERGY_MAX)
			amt = ENERGY_MAX;
		bt.index = clamp_pos(strip);
		bt.share = amt[ENERGY_W-1:0];
		bt.ovf   = ovf;
		bt.fin   = fin;
		pending_shares.push_back(bt);
	endtask

	// ------------------------------------------------------------------
	// Energy split of one accepted step over the strips it walks.
	// ------------------------------------------------------------------
	task automatic predict_shares(logic signed [POS_W-1:0] ent, logic signed [POS_W-1:0] ext,
			logic [ENERGY_W-1:0] en);
		longint w, a, b, base, sa, sb, span, total, dir, s, len, e;
		int k;
		// zero energy: nothing comes out
		if (en == '0)
			return;
		e    = longint'(en);
		// a zero width register acts as width one
		w    = (cfg_width == '0) ? 64'sd1 : longint'(cfg_width);
		a    = longint'(ent) - longint'(cfg_offset);
		b    = longint'(ext) - longint'(cfg_offset);
		base = longint'(cfg_nstrips >> 1) + 1;
		sa   = div_floor(a, w) + base;
		sb   = div_floor(b, w) + base;
		// both ends in one strip: that strip takes everything
		if (sa == sb) begin
			push_share(sa, e, 1'b0, 1'b1);
			return;
		end
		span = (sa < sb) ? (sb - sa + 1) : (sa - sb + 1);
		// walk too long: one flagged beat on the entry strip
		if (span > SPAN_LIMIT) begin
			push_share(sa, 0, 1'b1, 1'b1);
			return;
		end
		total = (b > a) ? (b - a) : (a - b);
		dir   = (sa < sb) ? 64'sd1 : -64'sd1;
		for (k = 0; k < span; k++) begin
			s = sa + dir * k;
			// entry and exit strips get the partial length to the edge in the
			// direction of travel; an entry on an edge can give zero here
			if (s == sa)
				len = (dir > 0) ? (w * div_ceil(a, w) - a) : (w * div_floor(a, w) - a);
			else if (s == sb)
				len = (dir > 0) ? (w * div_floor(b, w) - b) : (w * div_ceil(b, w) - b);
			else
				len = w;
			if (len < 0)
				len = -len;
			push_share(s, (e * len) / total, 1'b0, s == sb);
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: hold valid and payload until the beat is taken, predict on
	// acceptance, then either idle for a burst or offer the next step.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predict_shares(entry_pos, exit_pos, energy);
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (step_queue.size() != 0) begin
				step_t st;
				st = step_queue.pop_front();
				entry_pos <= st.entry_w;
				exit_pos  <= st.exit_w;
				energy    <= st.amount;
				in_valid  <= 1'b1;
				// schedule an idle burst after this beat goes through
				if (idle_on && $urandom_range(0, 4) == 0)
					gap_left <= $urandom_range(1, 8);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic flag_mismatch(string what, strip_beat_t want);
		if (mismatches < 10)
			$display("mismatch (%s): want idx=%0d e=%0d ovf=%0b last=%0b, got idx=%0d e=%0d ovf=%0b last=%0b",
				what, want.index, want.share, want.ovf, want.fin,
				strip_index, strip_energy, span_overflow, last);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Monitor: check each taken beat against the oldest prediction, and
	// drive out_ready: a long hold-off on request, short random stalls.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				strip_beat_t want;
				if (pending_shares.size() == 0) begin
					want = '{default: '0};
					flag_mismatch("unexpected beat", want);
				end else begin
					want = pending_shares.pop_front();
					if (strip_index !== want.index || strip_energy !== want.share ||
							span_overflow !== want.ovf || last !== want.fin)
						flag_mismatch("field", want);
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (holds_done != hold_requests) begin
				// start the long hold-off so the block backs up into its input
				out_ready  <= 1'b0;
				hold_left  <= LONG_HOLD;
				holds_done <= holds_done + 1;
			end else if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready  <= 1'b0;
				stall_left <= $urandom_range(0, 7);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: drop the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Configuration writes: setup cycle, then access cycle; the register
	// takes the value at the edge that ends the access cycle.
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_OFFSET:  cfg_offset  = value[POS_W-1:0];
			REG_WIDTH:   cfg_width   = value[SW_W-1:0];
			REG_NSTRIPS: cfg_nstrips = value[NS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(longint offset, int width, int nstrips);
		logic [DATA_W-1:0] word;
		word = offset[DATA_W-1:0];
		write_reg(REG_OFFSET, word);
		write_reg(REG_WIDTH, DATA_W'(width));
		write_reg(REG_NSTRIPS, DATA_W'(nstrips));
	endtask

	task automatic queue_step(longint ent, longint ext, longint en);
		step_t st;
		st.entry_w = clamp_pos(ent);
		st.exit_w  = clamp_pos(ext);
		st.amount  = en[ENERGY_W-1:0];
		step_queue.push_back(st);
	endtask

	// ------------------------------------------------------------------
	// Random step shaped by the current registers: entry mostly near the
	// detector, exit a chosen number of strips away, in either direction.
	// ------------------------------------------------------------------
	task automatic queue_random_step();
		logic signed [POS_W-1:0] raw;
		longint w, reach, a, b, d, en;
		int pick, n;
		w     = (cfg_width == '0) ? 64'sd1 : longint'(cfg_width);
		reach = (longint'(cfg_nstrips >> 1) + 4) * w;
		if (reach > POS_MAX)
			reach = POS_MAX;
		if ($urandom_range(0, 7) == 0) begin
			raw = POS_W'($urandom);
			a   = longint'(raw);
		end else begin
			a = longint'(cfg_offset) + longint'($urandom_range(0, int'(2 * reach))) - reach;
		end
		// now and then put the entry exactly on a strip edge
		if ($urandom_range(0, 7) == 0)
			a = longint'(cfg_offset) + div_floor(a - longint'(cfg_offset), w) * w;
		a = longint'(clamp_pos(a));

		pick = $urandom_range(0, 99);
		if (pick < 50)
			n = $urandom_range(1, 4);
		else if (pick < 80)
			n = $urandom_range(5, 12);
		else if (pick < 92)
			n = $urandom_range(13, SPAN_LIMIT);
		else
			n = $urandom_range(SPAN_LIMIT + 1, SPAN_LIMIT + 30);
		d = (n - 1) * w + longint'($urandom_range(0, int'(w - 1)));
		if ($urandom_range(0, 1) == 1)
			d = -d;
		b = a + d;
		if (b > POS_MAX || b < POS_MIN)
			b = a - d;
		if ($urandom_range(0, 7) == 0)
			b = longint'(cfg_offset) + div_floor(b - longint'(cfg_offset), w) * w;

		pick = $urandom_range(0, 19);
		if (pick == 0)
			en = 0;
		else if (pick == 1)
			en = ENERGY_MAX;
		else if (pick == 2)
			en = $urandom_range(1, 255);
		else
			en = longint'($urandom) & ENERGY_MAX;
		queue_step(a, b, en);
	endtask

	// Wait until every step is taken and every beat is back, then let the
	// block settle so stray beats or late work show up before moving on.
	task automatic drain();
		while (step_queue.size() != 0 || in_valid || pending_shares.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int count);
		repeat (count) queue_random_step();
		drain();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed steps at reset settings: offset 0, width 256, 40 strips.
		queue_step(100, 500, 0);                    // zero energy
		queue_step(10, 200, 1000);                  // one strip
		queue_step(0, 255, ENERGY_MAX);             // one strip, full energy
		queue_step(100, 400, 12345);                // two strips upward
		queue_step(400, 100, 12345);                // two strips downward
		queue_step(256, 700, 99999);                // entry on edge, upward
		queue_step(512, 100, 99999);                // entry on edge, downward
		queue_step(100, 512, 5000);                 // exit on edge
		queue_step(0, 63 * 256 + 10, ENERGY_MAX);   // longest allowed walk
		queue_step(0, 64 * 256 + 10, 777);          // one strip too many
		queue_step(0, -70 * 256, 777);              // too long, downward
		queue_step(POS_MIN, POS_MAX, ENERGY_MAX);   // position extremes
		queue_step(POS_MAX, POS_MAX, 1);
		queue_step(POS_MIN, POS_MIN, ENERGY_MAX);
		queue_step(-300, -10, 4242);                // negative side crossing
		queue_step(16137, 0, 1);                    // long walk, tiny energy
		drain();
		run_random(60);

		// single strip, width 100
		set_config(1234, 100, 1);
		run_random(60);

		// lowest offset, unit width, 256 strips: indices saturate high
		set_config(POS_MIN, 1, 256);
		queue_step(POS_MAX, POS_MAX - 7, 500);
		drain();
		run_random(50);

		// highest offset, widest strips; hold the receiver off for a while
		set_config(POS_MAX, 65535, 255);
		hold_requests = hold_requests + 1;
		run_random(50);

		// zero width acts as one; indices saturate low
		set_config(POS_MAX, 0, 3);
		queue_step(POS_MIN, POS_MIN + 3, 300);
		drain();
		run_random(40);

		// random settings with a second long hold-off
		set_config(longint'($urandom_range(0, 2000000)) - 1000000, $urandom_range(1, 4000),
			$urandom_range(1, 256));
		hold_requests = hold_requests + 1;
		run_random(80);

		// back to defaults, no idling on either side
		set_config(0, 256, 40);
		idle_on = 1'b0;
		run_random(80);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
